// ===== src/cnt_pkg.sv =====
// Package for the Carmichael number test: the default width constant and
// the sequencer states. No dependencies.
package cnt_pkg;

	localparam int unsigned NumberWidthDef = 16;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRIME_DIV,
		ST_PRIME_NEXT,
		ST_BASE,
		ST_GCD,
		ST_POW_BASE,
		ST_POW_MUL,
		ST_POW_SQR,
		ST_POW_CHECK,
		ST_DONE
	} state_t;

endpackage

// ===== src/cnt_mod_unit.sv =====
// Shared remainder unit: computes a % m for a double-width dividend by
// restoring division, one quotient bit a cycle. Uses cnt_pkg.
module cnt_mod_unit #(
	parameter int unsigned W = cnt_pkg::NumberWidthDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [2*W-1:0] dividend,
	input  logic [W-1:0]   divisor,
	output logic           busy,
	output logic           done,
	output logic [W-1:0]   remainder
);
	import cnt_pkg::*;

	localparam int unsigned CntW = $clog2(2 * W + 1);
	localparam logic [CntW-1:0] Steps = CntW'(2 * W);

	logic [2*W-1:0] dvd_q;
	logic [W:0]     rem_q;
	logic [W-1:0]   dsr_q;
	logic [CntW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [W:0]     trial;
	logic [W:0]     diff;

	always_comb begin
		trial = {rem_q[W-1:0], dvd_q[2*W-1]};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == Steps - 1'b1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[2*W-2:0], 1'b0};
			rem_q <= diff[W] ? trial : diff;
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign remainder = rem_q[W-1:0];

`ifndef ASSERT_OFF
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done without a finished division");
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done && dsr_q != '0 |-> rem_q[W-1:0] < dsr_q)
		else $error("remainder not below divisor");
	a_start_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !$past(busy) |-> $past(start))
		else $error("division began without start");
`endif
endmodule

// ===== src/cnt_seq.sv =====
// Sequencer for the Carmichael test: trial division, Euclid gcd and
// square-and-multiply, all through cnt_mod_unit. Uses cnt_pkg.
module cnt_seq #(
	parameter int unsigned W = cnt_pkg::NumberWidthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [W-1:0]        in_n,
	output logic                in_stall,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [W-1:0]        res_n,
	output logic                res_flag,
	output logic                mod_start,
	output logic [2*W-1:0]      mod_dividend,
	output logic [W-1:0]        mod_divisor,
	input  logic                mod_done,
	input  logic [W-1:0]        mod_rem
);
	import cnt_pkg::*;

	state_t         state_q, state_d;
	logic [W-1:0]   n_q;
	logic [W:0]     d_q;      // trial divisor, and base a
	logic [W-1:0]   x_q, y_q; // gcd operands
	logic [W-1:0]   b_q, acc_q;
	logic [W-1:0]   e_q;
	logic           flag_q;
	logic           out_v_q;
	logic           issued_q;
	logic [2*W+1:0] dsq;
	logic           done_fire;

	assign dsq = d_q * d_q;

	// A finished verdict moves into the result register once that register is
	// empty or its beat is being taken in the same cycle.
	assign done_fire = (state_q == ST_DONE) && (!out_v_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			out_v_q  <= 1'b0;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done_fire) out_v_q <= 1'b1;
			else if (res_valid && !res_stall) out_v_q <= 1'b0;
			if (mod_done) issued_q <= 1'b0;
			else if (mod_start) issued_q <= 1'b1;
		end
	end

	always_comb begin
		state_d      = state_q;
		mod_start    = 1'b0;
		mod_dividend = '0;
		mod_divisor  = n_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_PRIME_NEXT;
			ST_PRIME_NEXT: begin
				if (n_q < W'(2)) state_d = ST_DONE;
				else if (dsq > {{(W+2){1'b0}}, n_q}) state_d = ST_DONE;
				else state_d = ST_PRIME_DIV;
			end
			ST_PRIME_DIV: begin
				mod_start    = !issued_q;
				mod_dividend = {{W{1'b0}}, n_q};
				mod_divisor  = d_q[W-1:0];
				if (mod_done) state_d = (mod_rem == '0) ? ST_BASE : ST_PRIME_NEXT;
			end
			ST_BASE: begin
				if (d_q >= {1'b0, n_q}) state_d = ST_DONE;
				else if (!flag_q) state_d = ST_DONE;
				else state_d = ST_GCD;
			end
			ST_GCD: begin
				if (y_q == '0) state_d = (x_q == W'(1)) ? ST_POW_BASE : ST_BASE;
				else begin
					mod_start    = !issued_q;
					mod_dividend = {{W{1'b0}}, x_q};
					mod_divisor  = y_q;
				end
			end
			ST_POW_BASE: begin
				if (e_q == '0) state_d = ST_POW_CHECK;
				else if (e_q[0]) state_d = ST_POW_MUL;
				else state_d = ST_POW_SQR;
			end
			ST_POW_MUL: begin
				mod_start    = !issued_q;
				mod_dividend = acc_q * b_q;
				if (mod_done) state_d = ST_POW_SQR;
			end
			ST_POW_SQR: begin
				mod_start    = !issued_q;
				mod_dividend = b_q * b_q;
				if (mod_done) state_d = ST_POW_BASE;
			end
			ST_POW_CHECK: state_d = ST_BASE;
			ST_DONE: if (done_fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) begin
				n_q    <= in_n;
				d_q    <= (W+1)'(2);
				flag_q <= 1'b0;
			end
			ST_PRIME_NEXT: if (dsq > {{(W+2){1'b0}}, n_q} && n_q >= W'(2)) flag_q <= 1'b0;
			ST_PRIME_DIV: if (mod_done) begin
				if (mod_rem == '0) begin
					flag_q <= 1'b1;
					d_q    <= (W+1)'(2);
				end else d_q <= d_q + 1'b1;
			end
			ST_BASE: begin
				x_q <= d_q[W-1:0];
				y_q <= n_q;
			end
			ST_GCD: begin
				if (y_q == '0 && x_q == W'(1)) begin
					b_q   <= d_q[W-1:0];
					e_q   <= n_q - 1'b1;
					acc_q <= W'(1);
				end else if (y_q == '0) d_q <= d_q + 1'b1;
				else if (mod_done) begin
					x_q <= y_q;
					y_q <= mod_rem;
				end
			end
			ST_POW_MUL: if (mod_done) acc_q <= mod_rem;
			ST_POW_SQR: if (mod_done) begin
				b_q <= mod_rem;
				e_q <= e_q >> 1;
			end
			ST_POW_CHECK: begin
				if (acc_q != W'(1)) flag_q <= 1'b0;
				d_q <= d_q + 1'b1;
			end
			ST_DONE: if (done_fire) begin
				res_n    <= n_q;
				res_flag <= flag_q;
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign res_valid = out_v_q;

`ifndef ASSERT_OFF
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_PRIME_NEXT)
		else $error("accepted beat did not start a test");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");
	a_done_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> res_valid)
		else $error("finished test produced no result");
`endif
endmodule

// ===== src/carmichael_number_test.sv =====
// Top level of the Carmichael number test. Instantiates the sequencer and
// the shared remainder unit; depends on cnt_pkg, cnt_seq and cnt_mod_unit.
//
//   Channel  Signals                                  Dir  Beat
//   input    in_valid, in_stall, candidate            in   one number n
//   output   out_valid, out_stall, candidate_out,     out  echo and flag
//            is_carmichael
//
// Every remainder goes through the one restoring divider. A prime costs
// about sqrt(n) such operations; a composite costs the trial divisions
// up to its least factor, then per base a gcd (a few remainders) and, for
// a coprime base, up to 2*NUMBER_WIDTH remainders for the power. The test
// stops at the first base that fails. Reset clears the sequencer and the
// result valid. A result waits in its register while out_stall is high;
// the next number may be taken and tested meanwhile, and its verdict
// waits in the sequencer until the result register is free.
module carmichael_number_test #(
	parameter int unsigned NUMBER_WIDTH = cnt_pkg::NumberWidthDef
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [NUMBER_WIDTH-1:0] candidate,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [NUMBER_WIDTH-1:0] candidate_out,
	output logic                    is_carmichael
);
	import cnt_pkg::*;

	logic                      mod_start;
	logic [2*NUMBER_WIDTH-1:0] mod_dividend;
	logic [NUMBER_WIDTH-1:0]   mod_divisor;
	logic                      mod_busy;
	logic                      mod_done;
	logic [NUMBER_WIDTH-1:0]   mod_rem;

	// Sequencer walks the primality, gcd and power loops.
	cnt_seq #(.W(NUMBER_WIDTH)) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_n         (candidate),
		.in_stall     (in_stall),
		.res_valid    (out_valid),
		.res_stall    (out_stall),
		.res_n        (candidate_out),
		.res_flag     (is_carmichael),
		.mod_start    (mod_start),
		.mod_dividend (mod_dividend),
		.mod_divisor  (mod_divisor),
		.mod_done     (mod_done),
		.mod_rem      (mod_rem)
	);

	// Shared remainder unit serves every modulo of the test.
	cnt_mod_unit #(.W(NUMBER_WIDTH)) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mod_dividend),
		.divisor   (mod_divisor),
		.busy      (mod_busy),
		.done      (mod_done),
		.remainder (mod_rem)
	);

`ifndef ASSERT_OFF
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mod_start |-> !mod_busy)
		else $error("remainder issued while divider busy");
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			out_valid && $stable(candidate_out) && $stable(is_carmichael))
		else $error("stalled result changed");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |=> !mod_done)
		else $error("divider done held two cycles");
`endif
endmodule

// ===== dv/carmichael_number_test_test.sv =====
// Testbench for carmichael_number_test: drives candidate numbers, predicts the
// Carmichael flag with its own arithmetic and checks every result beat.
// Depends on cnt_pkg and the carmichael_number_test RTL only.
`timescale 1ns / 1ps

module carmichael_number_test_test;

	localparam int unsigned W = cnt_pkg::NumberWidthDef;
	localparam int unsigned RANDOM_COUNT = 81;
	// Idle cycles that may pass before the watchdog gives up. The slowest
	// legal beat here is 561, the smallest Carmichael number.
	localparam int unsigned IDLE_LIMIT = 3_000_000;

	typedef struct packed {
		logic [W-1:0] number;
		logic         flag;
	} verdict_t;

	logic         clk;
	logic         arst_n;
	logic         in_valid;
	logic         in_stall;
	logic [W-1:0] candidate;
	logic         out_valid;
	logic         out_stall;
	logic [W-1:0] candidate_out;
	logic         is_carmichael;

	logic [W-1:0] numbers_to_send[$];
	verdict_t     verdicts_due[$];
	int unsigned  total_items;
	int unsigned  numbers_taken;
	int unsigned  quiet_cycles;
	bit           failed;
	bit           stimulus_ready;

	carmichael_number_test #(.NUMBER_WIDTH(W)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.candidate    (candidate),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.candidate_out(candidate_out),
		.is_carmichael(is_carmichael)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Euclid's algorithm on wide values.
	function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
		longint unsigned r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// Square-and-multiply; products fit easily since the modulus is 16 bits.
	function automatic longint unsigned power_mod(longint unsigned b, longint unsigned e,
			longint unsigned m);
		longint unsigned acc;
		if (m < 2)
			return 0;
		acc = 1;
		b = b % m;
		while (e > 0) begin
			if (e[0])
				acc = (acc * b) % m;
			e = e >> 1;
			b = (b * b) % m;
		end
		return acc;
	endfunction

	// True when n is composite and every coprime base passes the Fermat test.
	function automatic bit carmichael_flag(logic [W-1:0] number);
		longint unsigned n;
		longint unsigned d;
		longint unsigned a;
		n = number;
		if (n < 2)
			return 1'b0;
		for (d = 2; d * d <= n; d++) begin
			if (n % d == 0)
				break;
		end
		if (d * d > n)
			return 1'b0; // prime
		for (a = 2; a < n; a++) begin
			if (gcd64(a, n) == 1 && power_mod(a, n - 1, n) != 1)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Idle percentages follow the three phases of the run: the sender idles
	// lightly and the receiver heavily, then the reverse, then neither.
	function automatic int unsigned sender_idle_pct();
		if (numbers_taken < total_items / 3)
			return 29;
		if (numbers_taken < 2 * total_items / 3)
			return 84;
		return 0;
	endfunction

	function automatic int unsigned receiver_idle_pct();
		if (numbers_taken < total_items / 3)
			return 84;
		if (numbers_taken < 2 * total_items / 3)
			return 29;
		return 0;
	endfunction

	// Stimulus. The block's cost grows with the number of bases below n
	// for a true Carmichael number, so only 561 is sent as one; any
	// random number that turns out to be a larger Carmichael number is drawn
	// again. Other large values end quickly at their first failing base.
	initial begin
		logic [W-1:0] n;
		stimulus_ready = 1'b0;
		// Zero and one, the smallest primes and composites, field extremes,
		// a large prime, base-2 pseudoprimes and the smallest Carmichael number.
		numbers_to_send = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd15, 16'd255,
			16'd561, 16'd341, 16'd645, 16'd1387, 16'd32768, 16'd65521, 16'd65534,
			16'd65535, 16'd65533, 16'd7, 16'd25};
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			do begin
				if ($urandom_range(99) < 40)
					n = W'($urandom_range(200));
				else
					n = W'($urandom);
			end while (n > 600 && carmichael_flag(n));
			numbers_to_send.push_back(n);
		end
		total_items = numbers_to_send.size();
		stimulus_ready = 1'b1;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: a beat leaves when accepted; the next number is presented only
	// after that, so valid stays high across back-to-back beats without a
	// second assignment in the same step.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			candidate <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				verdicts_due.push_back('{number: candidate, flag: carmichael_flag(candidate)});
				numbers_taken <= numbers_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (stimulus_ready && numbers_to_send.size() > 0 &&
						$urandom_range(99) >= sender_idle_pct()) begin
					in_valid  <= 1'b1;
					candidate <= numbers_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted result with the oldest prediction and
	// randomizes the stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t: result beat with nothing expected: n=%0d flag=%0b",
						$time, candidate_out, is_carmichael);
					failed = 1'b1;
				end else begin
					want = verdicts_due.pop_front();
					if (candidate_out !== want.number) begin
						$display("%0t: candidate_out expected %0d actual %0d",
							$time, want.number, candidate_out);
						failed = 1'b1;
					end
					if (is_carmichael !== want.flag) begin
						$display("%0t: is_carmichael for n=%0d expected %0b actual %0b",
							$time, want.number, want.flag, is_carmichael);
						failed = 1'b1;
					end
				end
			end
			out_stall <= ($urandom_range(99) < receiver_idle_pct());
		end
	end

	// Watchdog: counts cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		failed        = 1'b0;
		numbers_taken = 0;
		quiet_cycles  = 0;
		in_valid      = 1'b0;
		candidate     = '0;
		out_stall     = 1'b0;
		wait (stimulus_ready);
		while (numbers_to_send.size() != 0 || in_valid || verdicts_due.size() != 0)
			@(posedge clk);
		// Allow any stray extra beat to show up before the verdict.
		repeat (200) @(posedge clk);
		if (!failed)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
